FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the attitude rate setpoint block.
// No dependencies; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QA_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qars assertion failed");
`define QA_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qars assertion failed");
`else
`define QA_IMP(lbl, clk, rst_n, ante, cons)
`define QA_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/qars_pkg.sv
// Package of the attitude rate setpoint block: codes, sequencer states,
// control structs, the quaternion product term table and output saturation.
// No dependencies.
package qars_pkg;

	localparam logic [1:0] MODE_SET  = 2'd0;
	localparam logic [1:0] MODE_MEAS = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	localparam logic signed [15:0] ONE_Q14  = 16'sd16384;
	localparam logic [15:0]        KP_RESET = 16'd256;

	localparam logic signed [23:0] RATE_MAX = 24'sd8388607;
	localparam logic signed [23:0] RATE_MIN = -24'sd8388608;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_OUT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       vld;
		logic       first;
		logic       last;
		logic       neg;
		logic       out_rnd;
		logic [1:0] comp;
		state_t     ph;
	} mac_ctl_t;

	typedef struct packed {
		logic               vld;
		logic [1:0]         comp;
		state_t             ph;
		logic signed [34:0] value;
	} mac_res_t;

	typedef struct packed {
		logic [1:0] a_idx;
		logic [1:0] b_idx;
		logic       neg;
	} term_t;

	// Hamilton product term: component index x,y,z,w = 0..3, four terms each.
	function automatic term_t term_info(input logic [3:0] sel);
		term_t r;
		case (sel)
			4'd0:    r = '{2'd3, 2'd0, 1'b0};
			4'd1:    r = '{2'd0, 2'd3, 1'b0};
			4'd2:    r = '{2'd1, 2'd2, 1'b0};
			4'd3:    r = '{2'd2, 2'd1, 1'b1};
			4'd4:    r = '{2'd3, 2'd1, 1'b0};
			4'd5:    r = '{2'd0, 2'd2, 1'b1};
			4'd6:    r = '{2'd1, 2'd3, 1'b0};
			4'd7:    r = '{2'd2, 2'd0, 1'b0};
			4'd8:    r = '{2'd3, 2'd2, 1'b0};
			4'd9:    r = '{2'd0, 2'd1, 1'b0};
			4'd10:   r = '{2'd1, 2'd0, 1'b1};
			4'd11:   r = '{2'd2, 2'd3, 1'b0};
			4'd12:   r = '{2'd3, 2'd3, 1'b0};
			4'd13:   r = '{2'd0, 2'd0, 1'b1};
			4'd14:   r = '{2'd1, 2'd1, 1'b1};
			default: r = '{2'd2, 2'd2, 1'b1};
		endcase
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [34:0] v);
		logic signed [23:0] r;
		if (v > 35'(RATE_MAX))
			r = RATE_MAX;
		else if (v < 35'(RATE_MIN))
			r = RATE_MIN;
		else
			r = v[23:0];
		return r;
	endfunction

endpackage

FILE: rtl/qars_in_if.sv
// Input channel of the attitude rate setpoint block: valid, ready, mode and
// one quaternion. No dependencies.
interface qars_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;

	modport source (output valid, mode, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink (input valid, mode, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

FILE: rtl/qars_out_if.sv
// Result channel of the attitude rate setpoint block: valid, ready and the
// three rate setpoints. No dependencies.
interface qars_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] rate_x;
	logic signed [23:0] rate_y;
	logic signed [23:0] rate_z;

	modport source (output valid, rate_x, rate_y, rate_z, input ready);
	modport sink (input valid, rate_x, rate_y, rate_z, output ready);
endinterface

FILE: rtl/qars_mac.sv
// Shared multiply-accumulate unit: registered 26x17 signed multiply, then a
// signed accumulate with round seed and shift. Depends on qars_pkg.
module qars_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  qars_pkg::mac_ctl_t ctl,
	input  logic signed [25:0] op_a,
	input  logic signed [16:0] op_b,
	output qars_pkg::mac_res_t res
);
	import qars_pkg::*;

	logic signed [42:0] prod_s1;
	mac_ctl_t           ctl_s1;
	logic signed [43:0] acc_q;
	logic signed [43:0] base;
	logic signed [43:0] term;
	logic signed [43:0] acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (ctl_s1.vld) begin
			acc_q <= acc_next;
		end
	end

	always_comb begin
		if (ctl_s1.first)
			base = ctl_s1.out_rnd ? 44'sd256 : 44'sd8192;
		else
			base = acc_q;
		term = ctl_s1.neg ? -44'(prod_s1) : 44'(prod_s1);
		acc_next = base + term;
		res.vld = ctl_s1.vld && ctl_s1.last;
		res.comp = ctl_s1.comp;
		res.ph = ctl_s1.ph;
		if (ctl_s1.out_rnd)
			res.value = acc_next[43:9];
		else
			res.value = 35'($signed(acc_next[43:14]));
	end

endmodule

FILE: rtl/quaternion_attitude_rate_setpoint.sv
// Top level of the quaternion attitude rate setpoint block: sequencer,
// quaternion stores, APB gain register. Depends on qars_pkg, qars_in_if,
// qars_out_if, qars_mac and assert_macros.svh.
//
//  channel   kind        payload
//  item      vld/rdy in  mode, quat_x, quat_y, quat_z, quat_w
//  result    vld/rdy out rate_x, rate_y, rate_z
//  apb       cfg         kp_gain at byte address 0
//
// Store items are written into the quaternion stores on acceptance. A tick runs
// through the one shared multiply-accumulate unit in four passes of 16, 16, 12
// and 3 terms, with a settle step after each pass, then loads the result and
// returns to idle to accept the next item. Item ready is high only while idle.
// The result register holds one result; a finished tick waits until it is free. Reset is asynchronous.
`include "assert_macros.svh"

module quaternion_attitude_rate_setpoint (
	input  logic        clk,
	input  logic        arst_n,
	qars_in_if.sink     item,
	qars_out_if.source  result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import qars_pkg::*;

	state_t             state_q, state_d;
	logic [4:0]         cnt_q, cnt_d;
	logic [4:0]         n_terms;
	logic [15:0]        kp_q;
	logic               neg_e_q;
	logic               out_vld_q;
	logic signed [23:0] rx_q, ry_q, rz_q;
	logic               load_out;

	logic signed [15:0] tq_q [4];
	logic signed [15:0] mq_q [4];
	logic signed [19:0] eq_q [4];
	logic signed [22:0] cq_q [4];
	logic signed [25:0] bq_q [3];
	logic signed [23:0] rate_q [3];

	logic [1:0]         comp;
	term_t              ti;
	logic [1:0]         m_idx;
	logic signed [15:0] m_rd;
	logic signed [25:0] op_a;
	logic signed [16:0] op_b;
	mac_ctl_t           ctl;
	mac_res_t           res;
	logic               accept;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, kp_q};
	assign item.ready = (state_q == ST_IDLE);
	assign accept = item.valid && item.ready;

	assign result.valid = out_vld_q;
	assign result.rate_x = rx_q;
	assign result.rate_y = ry_q;
	assign result.rate_z = rz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= KP_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			kp_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		case (state_q)
			ST_P1, ST_P2: n_terms = 5'd16;
			ST_P3:        n_terms = 5'd12;
			default:      n_terms = 5'd3;
		endcase
		state_d = state_q;
		cnt_d = cnt_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (accept && item.mode == MODE_TICK)
					state_d = ST_P1;
			end
			ST_P1, ST_P2, ST_P3, ST_OUT: begin
				if (cnt_q == n_terms) begin
					cnt_d = '0;
					case (state_q)
						ST_P1:   state_d = ST_P2;
						ST_P2:   state_d = ST_P3;
						ST_P3:   state_d = ST_OUT;
						default: state_d = ST_DONE;
					endcase
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || result.ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		comp = (state_q == ST_OUT) ? cnt_q[1:0] : cnt_q[3:2];
		ti = term_info(cnt_q[3:0]);
		m_idx = (state_q == ST_P2) ? ti.a_idx : ti.b_idx;
		m_rd = mq_q[m_idx];
		case (state_q)
			ST_P1:   op_a = 26'(tq_q[ti.a_idx]);
			ST_P2:   op_a = 26'(eq_q[ti.b_idx]);
			ST_P3:   op_a = 26'(cq_q[ti.a_idx]);
			default: op_a = bq_q[comp];
		endcase
		op_b = (state_q == ST_OUT) ? $signed({1'b0, kp_q}) : 17'(m_rd);
		ctl.vld = (state_q inside {ST_P1, ST_P2, ST_P3, ST_OUT}) && (cnt_q < n_terms);
		ctl.first = (state_q == ST_OUT) || (cnt_q[1:0] == 2'd0);
		ctl.last = (state_q == ST_OUT) || (cnt_q[1:0] == 2'd3);
		ctl.out_rnd = (state_q == ST_OUT);
		ctl.comp = comp;
		ctl.ph = state_q;
		case (state_q)
			ST_P1:   ctl.neg = ti.neg ^ (ti.b_idx != 2'd3);
			ST_P2:   ctl.neg = ti.neg ^ (ti.a_idx != 2'd3) ^ neg_e_q;
			ST_P3:   ctl.neg = ti.neg;
			default: ctl.neg = 1'b1;
		endcase
	end

	qars_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tq_q <= '{16'sd0, 16'sd0, 16'sd0, ONE_Q14};
			mq_q <= '{16'sd0, 16'sd0, 16'sd0, ONE_Q14};
			neg_e_q <= 1'b0;
		end else begin
			if (accept) begin
				case (item.mode)
					MODE_SET:  tq_q <= '{item.quat_x, item.quat_y, item.quat_z, item.quat_w};
					MODE_MEAS: mq_q <= '{item.quat_x, item.quat_y, item.quat_z, item.quat_w};
					default: ;
				endcase
			end
			if (res.vld && res.ph == ST_P1 && res.comp == 2'd3)
				neg_e_q <= res.value[34];
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			case (res.ph)
				ST_P1:   eq_q[res.comp] <= res.value[19:0];
				ST_P2:   cq_q[res.comp] <= res.value[22:0];
				ST_P3:   bq_q[res.comp] <= res.value[25:0];
				ST_OUT:  rate_q[res.comp] <= sat24(res.value);
				default: ;
			endcase
		end
		if (load_out) begin
			rx_q <= rate_q[0];
			ry_q <= rate_q[1];
			rz_q <= rate_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	`QA_NEXT(a_tick_starts, clk, arst_n, accept && item.mode == MODE_TICK, state_q == ST_P1)
	`QA_IMP(a_wb_busy, clk, arst_n, res.vld, state_q != ST_IDLE && state_q != ST_DONE)
	`QA_NEXT(a_done_loads, clk, arst_n, state_q == ST_DONE && (!out_vld_q || result.ready), out_vld_q)

endmodule
